// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL; included by gnss_time_to_calendar.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GTC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gtc_pkg.sv =====
// Types and constants for the GNSS time to calendar converter.
// No dependencies; imported by gnss_time_to_calendar.
`default_nettype none

package gtc_pkg;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int CFG_W    = 7;

  // Register stages from the input register to the output register.
  localparam int PIPE_DEPTH = 11;

  localparam int POSIX_OFFSET   = 315964800;
  localparam int GLONASS_OFFSET = 10800;
  localparam int BDT_OFFSET     = 14;
  localparam int TAI_OFFSET     = 19;
  localparam int CYCLE_DAYS     = 365 * 4 + 1;
  localparam int YEAR_BASE      = 1970;

  typedef enum logic [2:0] {
    SYS_GPS     = 3'd0,
    SYS_GALILEO = 3'd1,
    SYS_QZSS    = 3'd2,
    SYS_BEIDOU  = 3'd3,
    SYS_GLONASS = 3'd4,
    SYS_UTC     = 3'd5,
    SYS_TAI     = 3'd6
  } time_sys_t;

  typedef enum logic [1:0] {
    REG_TIME_SYSTEM = 2'd0,
    REG_LEAP_NAV    = 2'd1,
    REG_LEAP_SET    = 2'd2
  } cfg_reg_t;

  // GPS times at which the leap count steps up by one; the count is the
  // number of steps at or before the time.
  localparam int LEAP_STEPS = 18;
  localparam logic [31:0] LEAP_START [LEAP_STEPS] = '{
    32'd46828801,   32'd78364802,   32'd109900803,  32'd173059204,
    32'd252028805,  32'd315187206,  32'd346723207,  32'd393984008,
    32'd425520009,  32'd457056010,  32'd504489611,  32'd551750412,
    32'd599184013,  32'd820108814,  32'd914803215,  32'd1025136016,
    32'd1119744017, 32'd1167264018
  };

  // First day of each year within the four-year cycle; the third is leap.
  localparam logic [10:0] YEAR_START [4] = '{11'd0, 11'd365, 11'd730, 11'd1096};
  localparam logic [1:0]  LEAP_YEAR_IDX  = 2'd2;

  localparam logic [8:0] MONTH_START_COMMON [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] MONTH_START_LEAP [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // Reciprocals for the constant divisions. 86400 = 128 * 675; the 675
  // quotient is corrected by one step, the others are exact over their range.
  localparam int DIV675_SHIFT = 36;
  localparam logic [26:0] RECIP_675 = 27'((64'd1 << DIV675_SHIFT) / 675);
  localparam int DIV60_SHIFT = 23;
  localparam logic [17:0] RECIP_60 = 18'(((64'd1 << DIV60_SHIFT) + 59) / 60);
  localparam int HOUR_SHIFT = 17;
  localparam logic [11:0] RECIP_60_SHORT = 12'(((64'd1 << HOUR_SHIFT) + 59) / 60);
  localparam int DIVCYC_SHIFT = 28;
  localparam logic [17:0] RECIP_CYCLE =
    18'(((64'd1 << DIVCYC_SHIFT) + CYCLE_DAYS - 1) / CYCLE_DAYS);

endpackage

`default_nettype wire

// ===== rtl/gnss_time_to_calendar.sv =====
// GNSS time to calendar converter: GPS seconds plus fraction in, broken-down
// date and time out. Depends on gtc_pkg and assert_macros.svh.
//
// Usage:
//   Input channel: drive gps_seconds and sub_second and raise start; the item
//   is taken at every rising edge with start high and busy low. busy stays low,
//   so a new timestamp may be offered in every cycle.
//   Result channel: done is high for exactly one cycle while year, month, day,
//   hour, minute, second and sub_second_out hold the result. The receiver
//   must take it in that cycle; it cannot push back.
//   Throughput is one item per cycle. The pipeline depth comes from the chain of
//   constant-divisor reciprocal multiplies (seconds to days, days to four-year
//   cycles, seconds of day to minutes and hours), each followed by a register.
//   Configuration: cfg_write with cfg_index selects time system (0), leap
//   override from navigation (1) or from settings (2); index 3 is ignored.
//   Write only while no item is in flight.
//   Reset clears all stage valids and loads GPS time with both leap overrides
//   unset; items in flight at reset are dropped.
`default_nettype none

`include "assert_macros.svh"

module gnss_time_to_calendar #(
  parameter int FRACTION_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   gps_seconds,
  input  logic [FRACTION_BITS-1:0]      sub_second,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [gtc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [gtc_pkg::YEAR_W-1:0]    year,
  output logic [gtc_pkg::MONTH_W-1:0]   month,
  output logic [gtc_pkg::DAY_W-1:0]     day,
  output logic [gtc_pkg::HOUR_W-1:0]    hour,
  output logic [gtc_pkg::MINUTE_W-1:0]  minute,
  output logic [gtc_pkg::SECOND_W-1:0]  second,
  output logic [FRACTION_BITS-1:0]      sub_second_out
);
  import gtc_pkg::*;

  logic [2:0]       time_sys;
  logic [CFG_W-1:0] leap_nav;
  logic [CFG_W-1:0] leap_set;

  logic [PIPE_DEPTH-1:0]    vld;
  logic [FRACTION_BITS-1:0] frac_line [PIPE_DEPTH];
  logic                     accept;

  // stage registers
  logic signed [33:0]    t0, t1;
  logic                  app0, app1;
  logic [LEAP_STEPS-1:0] ge1;
  logic [32:0]           posix2;
  logic [25:0]           x3;
  logic [6:0]            lo3, lo4;
  logic [16:0]           q3, q4;
  logic [10:0]           r4;
  logic [16:0]           rem5, days5, rem6, days6;
  logic [10:0]           mod6, mod7;
  logic [6:0]            cyc6, cyc7, cyc8, cyc9;
  logic [SECOND_W-1:0]   sec7, sec8, sec9;
  logic [HOUR_W-1:0]     hour7, hour8, hour9;
  logic [MINUTE_W-1:0]   min8, min9;
  logic [10:0]           doy7;
  logic [1:0]            y8, y9;
  logic [8:0]            d8, d9;
  logic [3:0]            mon9;

  // combinational terms
  logic signed [33:0] t_shift;
  logic               apply_leap;
  logic [5:0]         leap_used;
  logic signed [33:0] posix_sum;
  logic [52:0]        prod675;
  logic [26:0]        q_times;
  logic [26:0]        x_diff;
  logic [34:0]        prod_min;
  logic [34:0]        prod_cyc;
  logic [22:0]        prod_hour;
  logic [16:0]        min_times;
  logic [16:0]        cyc_times;
  logic [16:0]        hour_times;
  logic [1:0]         y_c;
  logic [10:0]        d_c;
  logic [3:0]         mon_c;
  logic [8:0]         mstart;

  assign accept = start && !busy;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_sys <= SYS_GPS;
      leap_nav <= '1;
      leap_set <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_SYSTEM: time_sys <= cfg_data[2:0];
        REG_LEAP_NAV:    leap_nav <= cfg_data;
        REG_LEAP_SET:    leap_set <= cfg_data;
        default: ;
      endcase
    end
  end

  // time system shift
  always_comb begin
    t_shift    = $signed({2'b00, gps_seconds});
    apply_leap = 1'b0;
    case (time_sys)
      SYS_BEIDOU:  t_shift = t_shift - 34'(BDT_OFFSET);
      SYS_GLONASS: begin
        t_shift    = t_shift + 34'(GLONASS_OFFSET);
        apply_leap = 1'b1;
      end
      SYS_UTC:     apply_leap = 1'b1;
      SYS_TAI:     t_shift = t_shift + 34'(TAI_OFFSET);
      default: ;
    endcase
  end

  // leap count: navigation override, then settings override, then table
  always_comb begin
    if (!leap_nav[CFG_W-1]) begin
      leap_used = leap_nav[5:0];
    end else if (!leap_set[CFG_W-1]) begin
      leap_used = leap_set[5:0];
    end else begin
      leap_used = 6'($countones(ge1));
    end
    posix_sum = t1 + 34'(POSIX_OFFSET) - (app1 ? {28'b0, leap_used} : 34'd0);
  end

  always_comb begin
    prod675    = {27'b0, posix2[32:7]} * {26'b0, RECIP_675};
    q_times    = 27'(q3) * 27'(675);
    x_diff     = {1'b0, x3} - q_times;
    prod_min   = {18'b0, rem5} * {17'b0, RECIP_60};
    prod_cyc   = {18'b0, days5} * {17'b0, RECIP_CYCLE};
    min_times  = 17'(mod6) * 17'(60);
    cyc_times  = 17'(cyc6) * 17'(CYCLE_DAYS);
    prod_hour  = {12'b0, mod6} * {11'b0, RECIP_60_SHORT};
    hour_times = 17'(hour7) * 17'(60);
  end

  // year within the four-year cycle
  always_comb begin
    y_c = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (doy7 >= YEAR_START[k]) y_c = 2'(k);
    end
    d_c = doy7 - YEAR_START[y_c];
  end

  // month from day of year; parallel compares against month starts
  always_comb begin
    mon_c = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (d8 >= ((y8 == LEAP_YEAR_IDX) ? MONTH_START_LEAP[k] : MONTH_START_COMMON[k]))
        mon_c = 4'(k);
    end
    mstart = (y9 == LEAP_YEAR_IDX) ? MONTH_START_LEAP[mon9] : MONTH_START_COMMON[mon9];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    frac_line[0] <= sub_second;
    for (int i = 1; i < PIPE_DEPTH; i++) frac_line[i] <= frac_line[i-1];

    // stage 0: shift into the output time system
    t0   <= t_shift;
    app0 <= apply_leap;
    // stage 1: compare against the leap steps
    t1   <= t0;
    app1 <= app0;
    for (int k = 0; k < LEAP_STEPS; k++) ge1[k] <= (t0 >= $signed({2'b00, LEAP_START[k]}));
    // stage 2: move onto the 1970 base
    posix2 <= posix_sum[32:0];
    // stage 3: estimate days = (posix >> 7) / 675
    x3  <= posix2[32:7];
    lo3 <= posix2[6:0];
    q3  <= prod675[DIV675_SHIFT+16:DIV675_SHIFT];
    // stage 4: remainder of the estimate
    q4  <= q3;
    lo4 <= lo3;
    r4  <= x_diff[10:0];
    // stage 5: correct the estimate by one step
    if (r4 >= 11'd675) begin
      days5 <= q4 + 17'd1;
      rem5  <= {10'(r4 - 11'd675), lo4};
    end else begin
      days5 <= q4;
      rem5  <= {r4[9:0], lo4};
    end
    // stage 6: minutes of day and four-year cycles
    rem6  <= rem5;
    days6 <= days5;
    mod6  <= prod_min[DIV60_SHIFT+10:DIV60_SHIFT];
    cyc6  <= prod_cyc[DIVCYC_SHIFT+6:DIVCYC_SHIFT];
    // stage 7: seconds, hours, day within the cycle
    sec7  <= SECOND_W'(rem6 - min_times);
    hour7 <= prod_hour[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
    mod7  <= mod6;
    doy7  <= 11'(days6 - cyc_times);
    cyc7  <= cyc6;
    // stage 8: minutes, year within the cycle
    min8  <= MINUTE_W'(17'(mod7) - hour_times);
    hour8 <= hour7;
    sec8  <= sec7;
    cyc8  <= cyc7;
    y8    <= y_c;
    d8    <= d_c[8:0];
    // stage 9: month
    mon9  <= mon_c;
    d9    <= d8;
    y9    <= y8;
    cyc9  <= cyc8;
    hour9 <= hour8;
    min9  <= min8;
    sec9  <= sec8;
    // stage 10: output register
    year   <= YEAR_W'(YEAR_BASE) + {3'b0, cyc9, 2'b00} + YEAR_W'(y9);
    month  <= mon9 + 4'd1;
    day    <= DAY_W'(d9 - mstart + 9'd1);
    hour   <= hour9;
    minute <= min9;
    second <= sec9;
  end

  assign done           = vld[PIPE_DEPTH-1];
  assign sub_second_out = frac_line[PIPE_DEPTH-1];

  `GTC_ASSERT_IMP(a_out_range, done, (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59), "result field out of range")
  `GTC_ASSERT_IMP(a_day_split, vld[5], (rem5 < 17'd86400), "seconds of day not below one day")
  `GTC_ASSERT_IMP(a_min_split, vld[6], (mod6 < 11'd1440 && cyc6 <= 7'd37), "minute or cycle count out of range")
  `GTC_ASSERT_NXT(a_leap_ovr, vld[1] && app1 && !leap_nav[CFG_W-1], (posix2 == 33'($past(t1) + 34'(POSIX_OFFSET) - {28'b0, $past(leap_nav[5:0])})), "navigation leap override not applied")

endmodule

`default_nettype wire
